// ----- hw/rtl/qcl_pkg.sv -----
// Shared constants, types and helper functions of the quadtree cell locator.
package qcl_pkg;

  localparam int MAX_SPLITS      = 15;
  localparam int COORD_FRAC_BITS = 16;
  localparam int PT_W            = 32;
  localparam int EXT_W           = 31;
  localparam int COORD_W         = PT_W + MAX_SPLITS + 1;
  localparam int LEAF_W          = 6;
  localparam int ID_W            = 6;
  localparam int LVL_W           = $clog2(MAX_SPLITS + 1);
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 31;
  localparam int QUAD_PER_LVL    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_LEAF_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_X     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_Y     = CFG_IDX_W'(2);

  localparam logic [LEAF_W-1:0] LEAF_RESET = LEAF_W'(1);

  localparam logic signed [PT_W-1:0] Z_LIM     = PT_W'(5 << COORD_FRAC_BITS);
  localparam logic signed [PT_W-1:0] NEG_Z_LIM = -Z_LIM;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_WALK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } walk_cmd_t;

  typedef struct packed {
    logic root_in;
    logic left;
    logic right;
    logic low;
    logic high;
  } walk_stat_t;

  // splits = ceil((max(leaf,1) - 1) / 3), saturated; /3 by reciprocal 43/128
  function automatic logic [LVL_W-1:0] split_count(input logic [LEAF_W-1:0] leaf);
    logic [LEAF_W:0]   n;
    logic [LEAF_W+6:0] prod;
    logic [LEAF_W:0]   q;
    n    = (leaf == '0) ? (LEAF_W+1)'(2) : ({1'b0, leaf} + (LEAF_W+1)'(1));
    prod = (LEAF_W+7)'(n) * (LEAF_W+7)'(43);
    q    = (LEAF_W+1)'(prod[LEAF_W+6:7]);
    if (q > (LEAF_W+1)'(MAX_SPLITS)) begin
      return LVL_W'(MAX_SPLITS);
    end
    return q[LVL_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/qcl_walk_unit.sv -----
// Coordinate registers and the shared midpoint and compare unit of the locator.
module qcl_walk_unit (
  input  logic                              clk,
  input  qcl_pkg::walk_cmd_t                cmd,
  input  logic signed [qcl_pkg::PT_W-1:0]   in_point_x,
  input  logic signed [qcl_pkg::PT_W-1:0]   in_point_y,
  input  logic signed [qcl_pkg::PT_W-1:0]   in_point_z,
  input  logic        [qcl_pkg::EXT_W-1:0]  half_extent_x,
  input  logic        [qcl_pkg::EXT_W-1:0]  half_extent_y,
  output qcl_pkg::walk_stat_t               stat
);
  import qcl_pkg::*;

  logic signed [COORD_W-1:0] px_r;
  logic signed [COORD_W-1:0] py_r;
  logic signed [PT_W-1:0]    pz_r;
  logic signed [COORD_W-1:0] x0_r;
  logic signed [COORD_W-1:0] y0_r;
  logic signed [COORD_W-1:0] x1_w;
  logic signed [COORD_W-1:0] y1_w;
  logic signed [COORD_W-1:0] sum_x;
  logic signed [COORD_W-1:0] sum_y;
  logic signed [COORD_W-1:0] mx;
  logic signed [COORD_W-1:0] my;

  assign x1_w = {{(COORD_W-EXT_W-MAX_SPLITS){1'b0}}, half_extent_x, {MAX_SPLITS{1'b0}}};
  assign y1_w = {{(COORD_W-EXT_W-MAX_SPLITS){1'b0}}, half_extent_y, {MAX_SPLITS{1'b0}}};

  assign sum_x = x0_r + x1_w;
  assign sum_y = y0_r + y1_w;
  assign mx    = sum_x >>> 1;
  assign my    = sum_y >>> 1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r <= {{(COORD_W-PT_W-MAX_SPLITS){in_point_x[PT_W-1]}}, in_point_x, {MAX_SPLITS{1'b0}}};
      py_r <= {{(COORD_W-PT_W-MAX_SPLITS){in_point_y[PT_W-1]}}, in_point_y, {MAX_SPLITS{1'b0}}};
      pz_r <= in_point_z;
      x0_r <= -x1_w;
      y0_r <= -y1_w;
    end else if (cmd.step) begin
      x0_r <= mx;
      y0_r <= my;
    end
  end

  always_comb begin
    stat.root_in = (pz_r >= NEG_Z_LIM) && (pz_r <= Z_LIM) &&
                   (px_r >= x0_r) && (px_r <= x1_w) &&
                   (py_r >= y0_r) && (py_r <= y1_w);
    stat.left    = (px_r <= mx);
    stat.right   = (px_r >= mx);
    stat.low     = (py_r <= my);
    stat.high    = (py_r >= my);
  end

endmodule

// ----- hw/rtl/qcl_seq.sv -----
// Level sequencer and result registers of the locator.
module qcl_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [qcl_pkg::LEAF_W-1:0]    leaf_count,
  input  qcl_pkg::walk_stat_t           stat,
  output logic                          busy,
  output qcl_pkg::walk_cmd_t            cmd,
  output logic                          out_valid,
  output logic                          out_found,
  output logic [qcl_pkg::ID_W-1:0]      out_cell_id
);
  import qcl_pkg::*;

  state_t            state_r;
  state_t            state_nxt;
  logic [LVL_W-1:0]  lvl_r;
  logic [LVL_W-1:0]  lvl_nxt;
  logic [ID_W-1:0]   base_r;
  logic [ID_W-1:0]   base_nxt;
  logic              found_r;
  logic              found_nxt;
  logic [ID_W-1:0]   id_r;
  logic [ID_W-1:0]   id_nxt;
  logic [LVL_W-1:0]  k_w;
  logic [LVL_W-1:0]  lvl_inc;
  logic              accept;
  logic              hit;
  logic              last;

  assign k_w     = split_count(leaf_count);
  assign lvl_inc = lvl_r + LVL_W'(1);
  assign busy    = !((state_r == ST_IDLE) || (state_r == ST_DONE));
  assign accept  = start && !busy;
  assign hit     = (stat.left && stat.low) || (stat.right && stat.low) ||
                   (stat.left && stat.high);
  assign last    = (lvl_inc == k_w);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (!stat.root_in || (k_w == '0)) state_nxt = ST_DONE;
        else state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (hit || last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = accept ? ST_ROOT : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load  = accept;
    cmd.step  = 1'b0;
    out_valid = 1'b0;
    lvl_nxt   = lvl_r;
    base_nxt  = base_r;
    found_nxt = found_r;
    id_nxt    = id_r;
    unique case (state_r)
      ST_IDLE: begin
      end
      ST_ROOT: begin
        lvl_nxt   = '0;
        base_nxt  = '0;
        found_nxt = stat.root_in;
        id_nxt    = '0;
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        lvl_nxt  = lvl_inc;
        base_nxt = base_r + ID_W'(QUAD_PER_LVL);
        priority if (stat.left && stat.low) begin
          id_nxt = base_r;
        end else if (stat.right && stat.low) begin
          id_nxt = base_r + ID_W'(1);
        end else if (stat.left && stat.high) begin
          id_nxt = base_r + ID_W'(2);
        end else begin
          id_nxt = base_r + ID_W'(QUAD_PER_LVL);
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lvl_r   <= '0;
      base_r  <= '0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
      base_r  <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    id_r    <= id_nxt;
  end

  assign out_found   = found_r;
  assign out_cell_id = id_r;

  a_miss_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_cell_id == '0))
    else $error("miss result carries nonzero cell id");

  a_id_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cell_id <= ID_W'(QUAD_PER_LVL * MAX_SPLITS)))
    else $error("cell id beyond last cell");

  a_walk_level: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (lvl_r < k_w))
    else $error("walk level past split count");

  a_accept_root: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_ROOT))
    else $error("accepted request did not enter root check");

  a_base_track: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (base_r == ID_W'(lvl_r) * ID_W'(QUAD_PER_LVL)))
    else $error("id base out of step with level");

endmodule

// ----- hw/rtl/quadtree_cell_locator.sv -----
// Top level of the quadtree cell locator: configuration registers and unit wiring.
//
// Usage: write target_leaf_count (index 0), half_extent_x (index 1) and
// half_extent_y (index 2) over the cfg_ channel while the block is idle;
// cfg_ready is always high, so a write lands at any edge with cfg_valid high.
// Raise start with in_point_x/y/z while busy is low to issue a request.
// The block checks the root rectangle and |z| <= 5 in a root-check state,
// then resolves one split level per cycle in a shared midpoint/compare unit.
// With k splits (set by the leaf count) the result strobe out_valid is high
// in the done state, which follows the root check for a miss or k = 0 and
// follows at most k walk levels otherwise; the walk stops at the first level
// that holds the point. A new request is taken in the strobe cycle, so a
// request is never taken while an earlier one is still being resolved.
// Each result shows for exactly one cycle; the receiver cannot stall it.
// Reset returns the sequencer to idle, sets the leaf count to 1 and both
// extents to 0.
module quadtree_cell_locator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [qcl_pkg::PT_W-1:0]     in_point_x,
  input  logic signed [qcl_pkg::PT_W-1:0]     in_point_y,
  input  logic signed [qcl_pkg::PT_W-1:0]     in_point_z,
  output logic                                out_valid,
  output logic                                out_found,
  output logic [qcl_pkg::ID_W-1:0]            out_cell_id,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qcl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qcl_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import qcl_pkg::*;

  logic [LEAF_W-1:0] leaf_r;
  logic [EXT_W-1:0]  half_x_r;
  logic [EXT_W-1:0]  half_y_r;
  walk_cmd_t         cmd;
  walk_stat_t        stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_r   <= LEAF_RESET;
      half_x_r <= '0;
      half_y_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LEAF_COUNT: leaf_r   <= cfg_data[LEAF_W-1:0];
        CFG_HALF_X:     half_x_r <= cfg_data[EXT_W-1:0];
        CFG_HALF_Y:     half_y_r <= cfg_data[EXT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  qcl_walk_unit u_walk (
    .clk           (clk),
    .cmd           (cmd),
    .in_point_x    (in_point_x),
    .in_point_y    (in_point_y),
    .in_point_z    (in_point_z),
    .half_extent_x (half_x_r),
    .half_extent_y (half_y_r),
    .stat          (stat)
  );

  qcl_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .leaf_count  (leaf_r),
    .stat        (stat),
    .busy        (busy),
    .cmd         (cmd),
    .out_valid   (out_valid),
    .out_found   (out_found),
    .out_cell_id (out_cell_id)
  );

endmodule

// ----- tb/tb_quadtree_cell_locator.sv -----
// Self-checking testbench for quadtree_cell_locator: directed and random point queries.
`timescale 1ns / 1ps

module tb_quadtree_cell_locator;
  import qcl_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int Z_SPAN = 5 << COORD_FRAC_BITS;
  localparam longint Z_BOUND = longint'(5) << COORD_FRAC_BITS;
  localparam longint COORD_SCALE = longint'(1) << MAX_SPLITS;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = CFG_IDX_W'(3);
  localparam logic signed [PT_W-1:0] PT_MIN = 32'sh8000_0000;
  localparam logic signed [PT_W-1:0] PT_MAX = 32'sh7FFF_FFFF;
  localparam logic [EXT_W-1:0] EXT_MAX = '1;
  localparam logic [EXT_W-1:0] EXT_POW2 = 31'h4000_0000;

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] id;
  } cell_result_t;

  typedef enum int {
    COORD_DEEP,
    COORD_INSIDE,
    COORD_GRID,
    COORD_EDGE,
    COORD_NOISE
  } coord_mode_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [PT_W-1:0]  in_point_x;
  logic signed [PT_W-1:0]  in_point_y;
  logic signed [PT_W-1:0]  in_point_z;
  logic                    out_valid;
  logic                    out_found;
  logic [ID_W-1:0]         out_cell_id;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  logic [LEAF_W-1:0]       model_leaf;
  logic [EXT_W-1:0]        model_half_x;
  logic [EXT_W-1:0]        model_half_y;

  cell_result_t            pending_cells[$];
  int                      fail_count = 0;
  int                      requests_sent;
  int                      results_checked = 0;
  int                      found_count = 0;
  int                      settings_used;
  int                      idle_cycles = 0;

  quadtree_cell_locator uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_point_x  (in_point_x),
    .in_point_y  (in_point_y),
    .in_point_z  (in_point_z),
    .out_valid   (out_valid),
    .out_found   (out_found),
    .out_cell_id (out_cell_id),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int splits_for(input logic [LEAF_W-1:0] leaf);
    int t;
    t = (leaf == '0) ? 1 : int'(leaf);
    t = (t + 1) / QUAD_PER_LVL;
    return (t > MAX_SPLITS) ? MAX_SPLITS : t;
  endfunction

  function automatic cell_result_t locate_cell(input logic signed [PT_W-1:0] x, y, z);
    longint       px, py, pz, x0, x1, y0, y1, mx, my;
    int           k;
    int           lvl;
    bit           done;
    cell_result_t r;
    px = longint'(x) * COORD_SCALE;
    py = longint'(y) * COORD_SCALE;
    pz = longint'(z);
    x1 = longint'({1'b0, model_half_x}) * COORD_SCALE;
    y1 = longint'({1'b0, model_half_y}) * COORD_SCALE;
    x0 = -x1;
    y0 = -y1;
    k = splits_for(model_leaf);
    r = '0;
    if (pz >= -Z_BOUND && pz <= Z_BOUND && px >= x0 && px <= x1 && py >= y0 && py <= y1) begin
      r.found = 1'b1;
      r.id = ID_W'(QUAD_PER_LVL * k);
      done = 1'b0;
      for (lvl = 0; lvl < k && !done; lvl++) begin
        mx = (x0 + x1) / 2;
        my = (y0 + y1) / 2;
        if (px <= mx && py <= my) begin
          r.id = ID_W'(QUAD_PER_LVL * lvl);
          done = 1'b1;
        end else if (px >= mx && py <= my) begin
          r.id = ID_W'(QUAD_PER_LVL * lvl + 1);
          done = 1'b1;
        end else if (px <= mx && py >= my) begin
          r.id = ID_W'(QUAD_PER_LVL * lvl + 2);
          done = 1'b1;
        end else begin
          x0 = mx;
          y0 = my;
        end
      end
    end
    return r;
  endfunction

  function automatic int next_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [EXT_W-1:0] pick_extent();
    int               p;
    logic [EXT_W-1:0] v;
    p = $urandom_range(0, 99);
    v = EXT_W'($urandom);
    if (p < 10) return '0;
    if (p < 20) return EXT_MAX;
    if (p < 40) return EXT_W'($urandom_range(0, 20 << COORD_FRAC_BITS));
    if (p < 60) return v & ~((EXT_W'(1) << $urandom_range(8, 24)) - EXT_W'(1));
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_leaf_word();
    int                    p;
    logic [CFG_DATA_W-1:0] w;
    p = $urandom_range(0, 99);
    w = CFG_DATA_W'($urandom);
    if (p < 12) w[LEAF_W-1:0] = '0;
    else if (p < 24) w[LEAF_W-1:0] = '1;
    else if (p < 34) w[LEAF_W-1:0] = LEAF_W'(46);
    else if (p < 44) w[LEAF_W-1:0] = LEAF_RESET;
    else w[LEAF_W-1:0] = LEAF_W'($urandom_range(0, 63));
    return w;
  endfunction

  function automatic logic signed [PT_W-1:0] pick_coord(input logic [EXT_W-1:0] half,
                                                        input coord_mode_t mode,
                                                        input int depth);
    longint          h, v;
    longint unsigned r;
    h = longint'({1'b0, half});
    r = {$urandom, $urandom};
    case (mode)
      COORD_DEEP: begin
        v = h - longint'(r % longint'((h >> depth) + 1));
      end
      COORD_INSIDE: begin
        v = -h + longint'(r % longint'(2 * h + 1));
      end
      COORD_GRID: begin
        v = h - (h >> depth);
        if ($urandom_range(0, 3) == 0) v = -v;
      end
      COORD_EDGE: begin
        case ($urandom_range(0, 3))
          0: v = h;
          1: v = -h;
          2: v = h + 1;
          default: v = -h - 1;
        endcase
      end
      default: begin
        v = longint'(r);
      end
    endcase
    return PT_W'(v);
  endfunction

  function automatic logic signed [PT_W-1:0] pick_z();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return PT_W'(longint'($urandom_range(0, 2 * Z_SPAN)) - Z_SPAN);
    if (p < 80) return $urandom_range(0, 1) ? Z_LIM : NEG_Z_LIM;
    if (p < 90) return $urandom_range(0, 1) ? Z_LIM + 1 : NEG_Z_LIM - 1;
    return PT_W'($urandom);
  endfunction

  task automatic send_point(input logic signed [PT_W-1:0] x, y, z);
    start      <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    do @(posedge clk); while (busy);
    pending_cells = {pending_cells, locate_cell(x, y, z)};
    requests_sent++;
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_cells.size() != 0 || busy) @(posedge clk);
    repeat (MAX_SPLITS + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LEAF_COUNT: model_leaf = data[LEAF_W-1:0];
      CFG_HALF_X:     model_half_x = data[EXT_W-1:0];
      CFG_HALF_Y:     model_half_y = data[EXT_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] leaf_word,
                            input logic [EXT_W-1:0] hx, hy);
    wait_idle();
    write_reg(CFG_LEAF_COUNT, leaf_word);
    write_reg(CFG_HALF_X, hx);
    write_reg(CFG_HALF_Y, hy);
    settings_used++;
  endtask

  task automatic send_random_point();
    int          p, d;
    coord_mode_t mode_x, mode_y;
    p = $urandom_range(0, 99);
    d = $urandom_range(0, MAX_SPLITS + 1);
    if (p < 40) begin
      mode_x = COORD_DEEP;
      mode_y = COORD_DEEP;
    end else if (p < 60) begin
      mode_x = COORD_INSIDE;
      mode_y = COORD_INSIDE;
    end else if (p < 75) begin
      mode_x = $urandom_range(0, 1) ? COORD_GRID : COORD_DEEP;
      mode_y = $urandom_range(0, 1) ? COORD_GRID : COORD_DEEP;
    end else if (p < 85) begin
      mode_x = COORD_EDGE;
      mode_y = $urandom_range(0, 1) ? COORD_EDGE : COORD_INSIDE;
    end else begin
      mode_x = COORD_NOISE;
      mode_y = COORD_NOISE;
    end
    if ($urandom_range(0, 1)) begin
      send_point(pick_coord(model_half_x, mode_x, d), pick_coord(model_half_y, mode_y, d),
                 pick_z());
    end else begin
      send_point(pick_coord(model_half_x, mode_y, d), pick_coord(model_half_y, mode_x, d),
                 pick_z());
    end
  endtask

  task automatic run_random_phase(input int count, input bit with_gaps);
    repeat (count) begin
      send_random_point();
      if (with_gaps) pause(next_gap());
      if ($urandom_range(0, 199) == 0) wait_idle();
    end
  endtask

  task automatic test_reset_state();
    send_point('0, '0, '0);
    send_point(32'sd1, '0, '0);
  endtask

  task automatic test_root_only();
    set_config('0, EXT_W'(10 << COORD_FRAC_BITS), EXT_W'(3 << COORD_FRAC_BITS));
    send_point(32'sd10 <<< COORD_FRAC_BITS, 32'sd3 <<< COORD_FRAC_BITS, '0);
    send_point(-(32'sd10 <<< COORD_FRAC_BITS), -(32'sd3 <<< COORD_FRAC_BITS), Z_LIM);
    send_point('0, '0, NEG_Z_LIM);
    send_point('0, '0, Z_LIM + 1);
    send_point('0, '0, NEG_Z_LIM - 1);
    send_point((32'sd10 <<< COORD_FRAC_BITS) + 1, '0, '0);
    send_point('0, -(32'sd3 <<< COORD_FRAC_BITS) - 1, '0);
    send_point(PT_MIN, PT_MAX, PT_MIN);
    send_point(PT_MAX, PT_MIN, PT_MAX);
  endtask

  task automatic test_deep_walk();
    set_config(CFG_DATA_W'(46), EXT_POW2, EXT_POW2);
    write_reg(CFG_UNMAPPED, CFG_DATA_W'(5));
    send_point(32'sh2000_0000, 32'sh2000_0000, Z_LIM);
    send_point(32'sh3FFF_FFFF, 32'sh3FFF_FFFF, NEG_Z_LIM);
    send_point(32'sh3FFF_0000, 32'sh3FFF_0000, '0);
    send_point(32'sh3FFF_FFFF, 32'sh3FFF_0000, '0);
    set_config(CFG_DATA_W'(46), EXT_MAX, EXT_MAX);
    send_point('0, '0, '0);
    send_point(PT_MAX, PT_MAX, '0);
    send_point(PT_MIN, '0, '0);
    send_point(-PT_MAX, -PT_MAX, '0);
    send_point(PT_MAX, -PT_MAX, '0);
    send_point(-PT_MAX, PT_MAX, '0);
  endtask

  task automatic test_leaf_saturation();
    set_config('1, EXT_POW2, EXT_POW2);
    send_point(32'sh3FFF_FFFF, 32'sh3FFF_FFFF, '0);
    set_config(CFG_DATA_W'(43), EXT_POW2, EXT_POW2);
    send_point(32'sh3FFF_FFFF, 32'sh3FFF_FFFF, '0);
    set_config(CFG_DATA_W'(2), EXT_POW2, EXT_POW2);
    send_point(32'sh3FFF_FFFF, 32'sh3FFF_FFFF, '0);
  endtask

  task automatic test_random_mix();
    repeat (11) begin
      set_config(pick_leaf_word(), pick_extent(), pick_extent());
      run_random_phase(150, 1'b1);
    end
  endtask

  task automatic test_back_to_back();
    set_config(pick_leaf_word(), pick_extent(), pick_extent());
    run_random_phase(150, 1'b0);
  endtask

  always @(posedge clk) begin : check_results
    cell_result_t want;
    if (rst_n && out_valid) begin
      if (pending_cells.size() == 0) begin
        $error("unexpected result: found=%0b cell_id=%0d", out_found, out_cell_id);
        fail_count++;
      end else begin
        want = pending_cells.pop_front();
        if (out_found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_found);
          fail_count++;
        end
        if (out_cell_id !== want.id) begin
          $error("cell_id: expected %0d, got %0d", want.id, out_cell_id);
          fail_count++;
        end
        results_checked++;
        if (want.found) found_count++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_cells.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_point_x      = '0;
    in_point_y      = '0;
    in_point_z      = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    model_leaf      = LEAF_RESET;
    model_half_x    = '0;
    model_half_y    = '0;
    requests_sent   = 0;
    settings_used   = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_root_only();
    test_deep_walk();
    test_leaf_saturation();
    test_random_mix();
    test_back_to_back();
    wait_idle();
    $display("Located %0d points (%0d inside a cell) under %0d register settings,",
             results_checked, found_count, settings_used);
    $display("from a bare root up to %0d splits, with zero and full extents and edge ties.",
             MAX_SPLITS);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/qcl_pkg.sv
hw/rtl/qcl_walk_unit.sv
hw/rtl/qcl_seq.sv
hw/rtl/quadtree_cell_locator.sv
tb/tb_quadtree_cell_locator.sv
